// ===== src/lia_pkg.sv =====
// Shared types, constants and ranking functions for the lobe integral and
// amplitude top-three unit. No dependencies.
`default_nettype none

package lia_pkg;

    localparam int SAMPLE_W = 16;
    localparam int DIFF_W   = SAMPLE_W + 1;
    localparam int INT_W    = 40;
    localparam int ACC_W    = INT_W + 1;
    localparam int SUM_W    = ACC_W + 1;
    localparam int AMP_W    = 16;
    localparam int TOP_N    = 3;

    localparam logic signed [SUM_W-1:0] INT_LIMIT = SUM_W'((64'd1 << INT_W) - 64'd1);

    localparam logic MODE_PROCESS = 1'b0;
    localparam logic MODE_CLEAR   = 1'b1;

    typedef struct packed {
        logic                       mode;
        logic signed [SAMPLE_W-1:0] sample;
    } t_in_req;

    typedef struct packed {
        logic [INT_W-1:0] best_integral;
        logic [INT_W-1:0] second_integral;
        logic [INT_W-1:0] third_integral;
        logic [AMP_W-1:0] best_amplitude;
        logic [AMP_W-1:0] second_amplitude;
        logic [AMP_W-1:0] third_amplitude;
        logic             lobe_closed;
    } t_out_req;

    typedef struct packed {
        logic             closed;
        logic [INT_W-1:0] abs_integral;
        logic [AMP_W-1:0] peak;
    } t_lobe_evt;

    typedef logic [TOP_N-1:0][INT_W-1:0] t_int_list;
    typedef logic [TOP_N-1:0][AMP_W-1:0] t_amp_list;

    function automatic t_int_list rank_int(t_int_list l, logic [INT_W-1:0] v);
        t_int_list r;
        r = l;
        if (v > l[0]) begin
            r[2] = l[1];
            r[1] = l[0];
            r[0] = v;
        end else if (v > l[1]) begin
            r[2] = l[1];
            r[1] = v;
        end else if (v > l[2]) begin
            r[2] = v;
        end
        return r;
    endfunction

    function automatic t_amp_list rank_amp(t_amp_list l, logic [AMP_W-1:0] v);
        t_amp_list r;
        r = l;
        if (v > l[0]) begin
            r[2] = l[1];
            r[1] = l[0];
            r[0] = v;
        end else if (v > l[1]) begin
            r[2] = l[1];
            r[1] = v;
        end else if (v > l[2]) begin
            r[2] = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/lobe_integral_amplitude_top3_unit.sv =====
// Top level of the lobe integral and amplitude top-three unit: input
// register, lobe tracker, ranking lists and result register.
// Depends on lia_pkg and lia_lobe.
//
//   channel  direction  handshake             payload
//   input    in         i_valid / o_stall     i_req  (t_in_req)
//   result   out        o_valid / i_stall     o_rsp  (t_out_req)
//   config   in         i_cfg_we              i_cfg_data (baseline)
//
// One request per cycle sustained while no result is held; a request's result
// passes through the input register, then the result register.
// The lobe update and both list insertions are combinational, registered on advance.
// Synchronous active-low reset clears the baseline, lobe state and lists.
// A held result stalls the input only once the input register is also full.
`default_nettype none

module lobe_integral_amplitude_top3_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire lia_pkg::t_in_req                    i_req,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output lia_pkg::t_out_req                        o_rsp,
    input  wire logic                                i_cfg_we,
    input  wire logic signed [lia_pkg::SAMPLE_W-1:0] i_cfg_data
);
    import lia_pkg::*;

    logic                       r_in_valid;
    t_in_req                    r_in;
    logic                       r_out_valid;
    t_out_req                   r_out;
    logic signed [SAMPLE_W-1:0] r_baseline;
    t_int_list                  r_top_int;
    t_int_list                  n_top_int;
    t_amp_list                  r_top_amp;
    t_amp_list                  n_top_amp;

    logic      out_ready;
    logic      advance;
    t_lobe_evt evt;
    t_out_req  n_out;

    assign out_ready = !r_out_valid || !i_stall;
    assign advance   = r_in_valid && out_ready;
    assign o_stall   = r_in_valid && !out_ready;
    assign o_valid   = r_out_valid;
    assign o_rsp     = r_out;

    lia_lobe u_lobe (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (advance),
        .i_req      (r_in),
        .i_baseline (r_baseline),
        .o_evt      (evt)
    );

    always_comb begin
        n_top_int = r_top_int;
        n_top_amp = r_top_amp;
        if (r_in.mode == MODE_CLEAR) begin
            n_top_int = '0;
            n_top_amp = '0;
        end else if (evt.closed) begin
            n_top_int = rank_int(r_top_int, evt.abs_integral);
            n_top_amp = rank_amp(r_top_amp, evt.peak);
        end
    end

    always_comb begin
        n_out.best_integral    = n_top_int[0];
        n_out.second_integral  = n_top_int[1];
        n_out.third_integral   = n_top_int[2];
        n_out.best_amplitude   = n_top_amp[0];
        n_out.second_amplitude = n_top_amp[1];
        n_out.third_amplitude  = n_top_amp[2];
        n_out.lobe_closed      = evt.closed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_baseline <= '0;
        end else if (i_cfg_we) begin
            r_baseline <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_int <= '0;
            r_top_amp <= '0;
        end else if (advance) begin
            r_top_int <= n_top_int;
            r_top_amp <= n_top_amp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

// ===== src/lia_lobe.sv =====
// Lobe tracker: baseline subtraction, saturating running integral and
// running peak, with sign-flip detection. Depends on lia_pkg.
`default_nettype none

module lia_lobe (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_en,
    input  wire lia_pkg::t_in_req                    i_req,
    input  wire logic signed [lia_pkg::SAMPLE_W-1:0] i_baseline,
    output lia_pkg::t_lobe_evt                       o_evt
);
    import lia_pkg::*;

    logic signed [ACC_W-1:0]  r_integral;
    logic signed [ACC_W-1:0]  n_integral;
    logic [AMP_W-1:0]         r_peak;
    logic [AMP_W-1:0]         n_peak;

    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]        diff_abs;
    logic [AMP_W-1:0]         mag;
    logic [ACC_W-1:0]         int_abs;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  sum_sat;
    logic                     int_pos;
    logic                     int_neg;
    logic                     flip;

    always_comb begin
        diff     = DIFF_W'($signed(i_req.sample)) - DIFF_W'($signed(i_baseline));
        diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
        mag      = diff_abs[AMP_W-1:0];
        int_neg  = r_integral[ACC_W-1];
        int_pos  = !r_integral[ACC_W-1] && (r_integral != '0);
        flip     = (int_pos && diff[DIFF_W-1]) ||
                   (int_neg && !diff[DIFF_W-1] && (diff != '0));
        int_abs  = int_neg ? ACC_W'(-r_integral) : ACC_W'(r_integral);
        sum      = SUM_W'(r_integral) + SUM_W'(diff);
        if (sum > INT_LIMIT) begin
            sum_sat = INT_LIMIT;
        end else if (sum < -INT_LIMIT) begin
            sum_sat = -INT_LIMIT;
        end else begin
            sum_sat = sum;
        end
    end

    always_comb begin
        n_integral = r_integral;
        n_peak     = r_peak;
        if (i_req.mode == MODE_CLEAR) begin
            n_integral = '0;
            n_peak     = '0;
        end else if (flip) begin
            n_integral = ACC_W'(diff);
            n_peak     = mag;
        end else begin
            n_integral = sum_sat[ACC_W-1:0];
            if (mag > r_peak) begin
                n_peak = mag;
            end
        end
    end

    always_comb begin
        o_evt.closed       = (i_req.mode == MODE_PROCESS) && flip;
        o_evt.abs_integral = int_abs[INT_W-1:0];
        o_evt.peak         = r_peak;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integral <= '0;
            r_peak     <= '0;
        end else if (i_en) begin
            r_integral <= n_integral;
            r_peak     <= n_peak;
        end
    end

endmodule

`default_nettype wire

// ===== sim/lobe_integral_amplitude_top3_unit_test.sv =====
// Self-checking testbench for lobe_integral_amplitude_top3_unit: directed and
// random samples with random idling on both channels, checked against a predictor.
// Depends on lia_pkg and the unit itself.
`default_nettype none

module lobe_integral_amplitude_top3_unit_test;
    import lia_pkg::*;

    localparam longint SUM_MAX = (longint'(1) << INT_W) - 1;

    logic                       i_clk      = 1'b0;
    logic                       i_rst_n    = 1'b0;
    logic                       i_valid    = 1'b0;
    logic                       o_stall;
    t_in_req                    i_req      = '0;
    logic                       o_valid;
    logic                       i_stall    = 1'b0;
    t_out_req                   o_rsp;
    logic                       i_cfg_we   = 1'b0;
    logic signed [SAMPLE_W-1:0] i_cfg_data = '0;

    lobe_integral_amplitude_top3_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_req      (i_req),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_rsp      (o_rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    longint           lobe_sum  = 0;
    longint           lobe_peak = 0;
    longint           base_lvl  = 0;
    logic [INT_W-1:0] top_int[TOP_N] = '{default: '0};
    logic [AMP_W-1:0] top_amp[TOP_N] = '{default: '0};
    t_out_req         rank_q[$];

    int calm       = 0;
    int errors     = 0;
    int n_reqs     = 0;
    int n_results  = 0;
    int n_closed   = 0;
    int n_clears   = 0;
    int hold_cnt   = 0;
    int hold_draw  = 0;
    bit rsp_taken  = 1'b0;

    function automatic int draw_wait();
        if (calm != 0) return 0;
        if ($urandom_range(0, 2) == 0) return $urandom_range(0, 13);
        return 0;
    endfunction

    function automatic t_out_req predict_lobe(t_in_req r);
        longint           d;
        longint           mag;
        longint           s;
        logic [INT_W-1:0] ai;
        logic [AMP_W-1:0] pk;
        bit               done;
        int               k;
        int               j;
        t_out_req         o;
        o = '0;
        if (r.mode == MODE_CLEAR) begin
            lobe_sum  = 0;
            lobe_peak = 0;
            for (k = 0; k < TOP_N; k++) begin
                top_int[k] = '0;
                top_amp[k] = '0;
            end
        end else begin
            d   = longint'(r.sample) - base_lvl;
            mag = (d < 0) ? -d : d;
            if ((lobe_sum > 0 && d < 0) || (lobe_sum < 0 && d > 0)) begin
                ai   = INT_W'((lobe_sum < 0) ? -lobe_sum : lobe_sum);
                pk   = AMP_W'(lobe_peak);
                done = 1'b0;
                for (k = 0; k < TOP_N; k++) begin
                    if (!done && ai > top_int[k]) begin
                        for (j = TOP_N - 1; j > k; j--) top_int[j] = top_int[j-1];
                        top_int[k] = ai;
                        done = 1'b1;
                    end
                end
                done = 1'b0;
                for (k = 0; k < TOP_N; k++) begin
                    if (!done && pk > top_amp[k]) begin
                        for (j = TOP_N - 1; j > k; j--) top_amp[j] = top_amp[j-1];
                        top_amp[k] = pk;
                        done = 1'b1;
                    end
                end
                lobe_sum      = d;
                lobe_peak     = mag;
                o.lobe_closed = 1'b1;
            end else begin
                s = lobe_sum + d;
                if (s > SUM_MAX) s = SUM_MAX;
                if (s < -SUM_MAX) s = -SUM_MAX;
                lobe_sum = s;
                if (mag > lobe_peak) lobe_peak = mag;
            end
        end
        o.best_integral    = top_int[0];
        o.second_integral  = top_int[1];
        o.third_integral   = top_int[2];
        o.best_amplitude   = top_amp[0];
        o.second_amplitude = top_amp[1];
        o.third_amplitude  = top_amp[2];
        return o;
    endfunction

    task automatic send_req(input logic mode, input logic signed [SAMPLE_W-1:0] smp);
        int      gap;
        bit      stl;
        t_in_req r;
        r.mode   = mode;
        r.sample = smp;
        gap      = draw_wait();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= r;
        do begin
            @(negedge i_clk);
            stl = o_stall;
            @(posedge i_clk);
        end while (stl);
        rank_q.push_back(predict_lobe(r));
        n_reqs++;
        if (mode == MODE_CLEAR) n_clears++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (rank_q.size() != 0);
    endtask

    task automatic write_baseline(input logic signed [SAMPLE_W-1:0] v);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        base_lvl   = longint'(v);
    endtask

    task automatic check_rsp(input t_out_req got);
        t_out_req         want;
        logic [INT_W-1:0] w[7];
        logic [INT_W-1:0] g[7];
        string            fld[7] = '{"best_integral", "second_integral", "third_integral",
                                     "best_amplitude", "second_amplitude",
                                     "third_amplitude", "lobe_closed"};
        int               k;
        n_results++;
        if (got.lobe_closed) n_closed++;
        if (rank_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %h", got);
            return;
        end
        want = rank_q.pop_front();
        w = '{want.best_integral, want.second_integral, want.third_integral,
              INT_W'(want.best_amplitude), INT_W'(want.second_amplitude),
              INT_W'(want.third_amplitude), INT_W'(want.lobe_closed)};
        g = '{got.best_integral, got.second_integral, got.third_integral,
              INT_W'(got.best_amplitude), INT_W'(got.second_amplitude),
              INT_W'(got.third_amplitude), INT_W'(got.lobe_closed)};
        for (k = 0; k < 7; k++) begin
            if (g[k] !== w[k]) begin
                errors++;
                if (errors <= 10)
                    $display("result %0d %s: expected %0d, got %0d",
                             n_results, fld[k], w[k], g[k]);
            end
        end
    endtask

    always @(negedge i_clk) begin
        rsp_taken = i_rst_n && o_valid && !i_stall;
        if (rsp_taken) check_rsp(o_rsp);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall  <= 1'b0;
            hold_cnt <= 0;
        end else if (rsp_taken) begin
            hold_draw = draw_wait();
            hold_cnt <= hold_draw;
            i_stall  <= (hold_draw != 0);
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
            i_stall  <= (hold_cnt > 1);
        end
    end

    task automatic test_reset_view();
        send_req(MODE_PROCESS, 16'sh0000);
    endtask

    task automatic test_extremes();
        send_req(MODE_PROCESS, 16'sh7FFF);
        send_req(MODE_PROCESS, 16'sh7FFF);
        send_req(MODE_PROCESS, 16'sh8000);
        send_req(MODE_PROCESS, 16'sh8000);
        send_req(MODE_PROCESS, 16'sh0000);
        send_req(MODE_PROCESS, 16'sh0001);
        send_req(MODE_PROCESS, 16'shFFFF);
        send_req(MODE_PROCESS, 16'shFFFF);
    endtask

    task automatic test_ties();
        int k;
        send_req(MODE_CLEAR, 16'sh1234);
        for (k = 0; k < 6; k++) send_req(MODE_PROCESS, (k % 2 == 0) ? 16'sd3 : -16'sd3);
    endtask

    task automatic test_clear();
        send_req(MODE_CLEAR, 16'sh8000);
        send_req(MODE_CLEAR, 16'sh7FFF);
    endtask

    task automatic test_baseline_extremes();
        write_baseline(16'sh8000);
        send_req(MODE_PROCESS, 16'sh7FFF);
        send_req(MODE_PROCESS, 16'sh8000);
        write_baseline(16'sh7FFF);
        send_req(MODE_PROCESS, 16'sh8000);
        send_req(MODE_PROCESS, 16'sh7FFF);
    endtask

    task automatic test_random_lobes();
        logic signed [SAMPLE_W-1:0] bl;
        int                         p;
        int                         n;
        int                         len;
        longint                     sgn;
        longint                     mag;
        longint                     tgt;
        for (p = 0; p < 6; p++) begin
            case (p)
                0:       bl = 16'sh0000;
                1:       bl = 16'sh8000;
                2:       bl = 16'sh7FFF;
                default: bl = SAMPLE_W'($urandom);
            endcase
            write_baseline(bl);
            calm = (p == 1 || p == 4);
            sgn  = $urandom_range(0, 1) ? 1 : -1;
            n    = 0;
            while (n < 170) begin
                len = $urandom_range(1, 12);
                repeat (len) begin
                    case ($urandom_range(0, 19))
                        0:    send_req(MODE_CLEAR, SAMPLE_W'($urandom));
                        1, 2: send_req(MODE_PROCESS, SAMPLE_W'($urandom));
                        default: begin
                            case ($urandom_range(0, 3))
                                0:       mag = $urandom_range(0, 15);
                                1:       mag = $urandom_range(0, 1000);
                                default: mag = $urandom_range(0, 65535);
                            endcase
                            tgt = base_lvl + sgn * mag;
                            if (tgt > 32767) tgt = 32767;
                            if (tgt < -32768) tgt = -32768;
                            send_req(MODE_PROCESS, SAMPLE_W'(tgt));
                        end
                    endcase
                    n++;
                end
                sgn = -sgn;
                if ($urandom_range(0, 40) == 0) drain();
            end
        end
        calm = 0;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_view();
        test_extremes();
        test_ties();
        test_clear();
        test_baseline_extremes();
        test_random_lobes();
        drain();
        repeat (6) @(posedge i_clk);
        $display("%0d requests (%0d clears) gave %0d results with %0d closed lobes,",
                 n_reqs, n_clears, n_results, n_closed);
        $display("over baselines at both extremes, zero and random, with idle and stall gaps");
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches", errors);
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
